FILE: sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } shift_t;

  // Control part of the lookup token that travels down the row.
  typedef struct packed {
    logic valid;
    logic hit;
  } scan_t;

endpackage

`default_nettype wire

FILE: sv/ple_cell.sv
`default_nettype none

module ple_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 7,
  parameter int AW         = 6,
  parameter int INDEX      = 0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  ple_pkg::shift_t       shift,
  input  wire  [AW-1:0]         at,
  input  wire  [DATA_WIDTH-1:0] key,
  input  wire                   find,
  input  wire  [CW-1:0]         count,
  input  wire  [DATA_WIDTH-1:0] left,
  input  wire  [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] slot,
  input  ple_pkg::scan_t        scan_in,
  input  wire  [DATA_WIDTH-1:0] scan_val_in,
  input  wire  [CW-1:0]         scan_pos_in,
  output ple_pkg::scan_t        scan_out,
  output logic [DATA_WIDTH-1:0] scan_val_out,
  output logic [CW-1:0]         scan_pos_out
);

  logic [DATA_WIDTH-1:0] slot_next;
  logic                  here;
  logic                  above;
  logic                  mine;

  assign here  = (at == AW'(INDEX));
  assign above = (AW'(INDEX) > at);

  always_comb begin
    slot_next = slot;
    if (shift.ins) begin
      if (here) begin
        slot_next = key;
      end else if (above) begin
        slot_next = left;
      end
    end else if (shift.rem) begin
      if (here || above) begin
        slot_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  // A find matches only inside the occupied part of the list.
  assign mine = find ? ((CW'(INDEX) < count) && (slot == key)) : here;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out.valid <= scan_in.valid;
      scan_out.hit   <= scan_in.hit | (scan_in.valid & mine);
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.hit) begin
      scan_val_out <= scan_val_in;
      scan_pos_out <= scan_pos_in;
    end else begin
      scan_val_out <= slot;
      scan_pos_out <= CW'(INDEX + 1);
    end
  end

endmodule

`default_nettype wire

FILE: sv/positional_list_engine_core.sv
// Positional list engine: an ordered list of values addressed by 1-based
// position, held in a row of cells that shift toward or away from the head.
// Input channel (in_valid/in_stall) carries opcode, position and value; the
// output channel (out_valid/out_stall) returns one result item per input item
// with ok, result_value, found_position, length and is_empty.
// Insert, and a rejected remove or read, produce the result in the cycle after
// the item is accepted. Find, and a valid read or remove, send a lookup token down
// the row, one cell per cycle, and the result is registered as the token leaves
// the last cell; a remove commits its shift when the token leaves the last cell.
// The block holds one item at a time: in_stall is high while a lookup is in
// flight, and while a result waits on a stalled receiver. A result that the
// receiver is taking does not block the next item.
// Reset empties the list (length 0); slot contents are not cleared since
// positions beyond the length are never read.
`default_nettype none

module positional_list_engine_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int PW = $clog2(CAPACITY + 2),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         opcode,
  input  wire  [PW-1:0]      position,
  input  wire  signed [31:0] value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               ok,
  output logic signed [31:0] result_value,
  output logic [CW-1:0]      found_position,
  output logic [CW-1:0]      length,
  output logic               is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state;
  logic                  start;
  logic [1:0]            op_reg;
  logic [AW-1:0]         at_reg;
  logic [DATA_WIDTH-1:0] key_reg;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  logic                  accept;
  logic                  pos_nz;
  logic                  ins_ok;
  logic                  idx_ok;
  logic                  needs_scan;
  logic                  scan_done;
  logic [AW-1:0]         shift_at;
  logic [DATA_WIDTH-1:0] key_in;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH+31:0] key_ext;
  logic [DATA_WIDTH+31:0] rv_ext;
  logic [PW:0]           pos_ext;
  logic [PW:0]           cnt_ext;
  ple_pkg::shift_t       shift;

  ple_pkg::scan_t        scan_flags [CAPACITY+1];
  logic [DATA_WIDTH-1:0] scan_val   [CAPACITY+1];
  logic [CW-1:0]         scan_pos   [CAPACITY+1];
  logic [DATA_WIDTH-1:0] slots      [CAPACITY];

  assign accept   = in_valid & ~in_stall;
  assign in_stall = (state != ST_IDLE) | (out_valid & out_stall);

  // Values are stored on their low DATA_WIDTH bits, zero-extended when wider.
  assign key_ext = {{DATA_WIDTH{1'b0}}, value};
  assign key_in  = key_ext[DATA_WIDTH-1:0];
  assign key     = (state == ST_IDLE) ? key_in : key_reg;

  assign pos_ext = {1'b0, position};
  assign cnt_ext = (PW + 1)'(count);
  assign pos_nz  = (position != '0);
  assign ins_ok  = pos_nz && (pos_ext <= cnt_ext + 1'b1) && (count < CW'(CAPACITY));
  assign idx_ok  = pos_nz && (pos_ext <= cnt_ext);

  assign needs_scan = (opcode == ple_pkg::OP_FIND) ||
                      (((opcode == ple_pkg::OP_REMOVE) || (opcode == ple_pkg::OP_READ)) &&
                       idx_ok);

  assign scan_done = scan_flags[CAPACITY].valid;
  assign shift_at  = (state == ST_IDLE) ? AW'(position - 1'b1) : at_reg;
  assign shift.ins = accept && (opcode == ple_pkg::OP_INSERT) && ins_ok;
  assign shift.rem = scan_done && (op_reg == ple_pkg::OP_REMOVE);

  always_comb begin
    count_next = count;
    if (shift.ins) begin
      count_next = count + 1'b1;
    end else if (shift.rem) begin
      count_next = count - 1'b1;
    end
  end

  assign scan_flags[0].valid = start;
  assign scan_flags[0].hit   = 1'b0;
  assign scan_val[0]         = '0;
  assign scan_pos[0]         = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .AW         (AW),
      .INDEX      (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift        (shift),
      .at           (shift_at),
      .key          (key),
      .find         (op_reg == ple_pkg::OP_FIND),
      .count        (count),
      .left         ((i == 0) ? key : slots[(i == 0) ? 0 : i - 1]),
      .right        (slots[(i == CAPACITY - 1) ? i : i + 1]),
      .slot         (slots[i]),
      .scan_in      (scan_flags[i]),
      .scan_val_in  (scan_val[i]),
      .scan_pos_in  (scan_pos[i]),
      .scan_out     (scan_flags[i+1]),
      .scan_val_out (scan_val[i+1]),
      .scan_pos_out (scan_pos[i+1])
    );
  end

  assign rv_ext = {32'd0, scan_val[CAPACITY]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      start <= accept & needs_scan;
      case (state)
        ST_IDLE: begin
          if (accept && needs_scan) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if ((accept && !needs_scan) || scan_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= opcode;
      at_reg  <= AW'(position - 1'b1);
      key_reg <= key_in;
    end
    if (accept && !needs_scan) begin
      ok             <= (opcode == ple_pkg::OP_INSERT) && ins_ok;
      result_value   <= '0;
      found_position <= '0;
      length         <= count_next;
      is_empty       <= (count_next == '0);
    end else if (scan_done) begin
      if (op_reg == ple_pkg::OP_FIND) begin
        ok             <= scan_flags[CAPACITY].hit;
        result_value   <= '0;
        found_position <= scan_flags[CAPACITY].hit ? scan_pos[CAPACITY] : '0;
      end else begin
        ok             <= 1'b1;
        result_value   <= rv_ext[31:0];
        found_position <= '0;
      end
      length   <= count_next;
      is_empty <= (count_next == '0);
    end
  end

`ifndef SYNTHESIS
  a_no_result_during_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !out_valid)
    else $error("result pending while a lookup is in flight");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == ST_SCAN))
    else $error("lookup token left the row outside a lookup");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !needs_scan) |=> (out_valid && (state == ST_IDLE)))
    else $error("immediate result missing");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_positional_list_engine_core.sv
`default_nettype none

module tb_positional_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int LATENCY = CAPACITY + 2;
  localparam int NUM_RANDOM = 1500;
  localparam int SEGMENT = 100;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]         op;
    logic [6:0]         pos;
    logic signed [31:0] val;
  } list_op_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] rv;
    logic [6:0]         fpos;
    logic [6:0]         len;
    logic               empty;
  } list_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = ple_pkg::OP_INSERT;
  logic [6:0] position = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic signed [31:0] result_value;
  logic [6:0] found_position;
  logic [6:0] length;
  logic is_empty;

  positional_list_engine_core #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .result_value(result_value),
    .found_position(found_position),
    .length(length),
    .is_empty(is_empty)
  );

  list_op_t pending_ops[$];
  list_reply_t expected_replies[$];

  // Predicted list contents, kept in step with the accepted items.
  logic signed [31:0] shadow_list [CAPACITY];
  int shadow_len = 0;

  // Length as seen by the generator, which runs ahead of the block.
  int gen_len = 0;
  int queued = 0;
  int accepted = 0;
  int errors = 0;
  int cycles = 0;
  logic in_fire = 1'b0;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic list_reply_t apply_list_op(list_op_t o);
    list_reply_t r;
    int at;
    int i;
    r = '0;
    at = int'(o.pos) - 1;
    case (o.op)
      ple_pkg::OP_INSERT: begin
        if (o.pos >= 1 && o.pos <= shadow_len + 1 && shadow_len < CAPACITY) begin
          for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = o.val;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (o.pos >= 1 && o.pos <= shadow_len) begin
          r.rv = shadow_list[at];
          for (i = at; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      ple_pkg::OP_READ: begin
        if (o.pos >= 1 && o.pos <= shadow_len) begin
          r.rv = shadow_list[at];
          r.ok = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < shadow_len && !r.ok; i++) begin
          if (shadow_list[i] == o.val) begin
            r.ok = 1'b1;
            r.fpos = 7'(i + 1);
          end
        end
      end
    endcase
    r.len = 7'(shadow_len);
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic push_op(logic [1:0] op, int pos, logic [31:0] val);
    list_op_t o;
    o.op = op;
    o.pos = 7'(pos);
    o.val = val;
    pending_ops.push_back(o);
    queued++;
    if (op == ple_pkg::OP_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (op == ple_pkg::OP_REMOVE && pos >= 1 && pos <= gen_len)
      gen_len--;
  endtask

  // A small pool of repeated values keeps finds hitting and leaves duplicates.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'(($urandom_range(0, 3)));
      default: return $urandom;
    endcase
  endfunction

  // Mode 0 fills the list, mode 1 drains it, mode 2 mixes all four with inserts ahead of removes.
  task automatic push_random_op(int mode);
    int w;
    int hi;
    int pos;
    logic [1:0] op;
    w = $urandom_range(0, 99);
    case (mode)
      0: op = (w < 70) ? ple_pkg::OP_INSERT : (w < 80) ? ple_pkg::OP_REMOVE :
              (w < 90) ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
      1: op = (w < 15) ? ple_pkg::OP_INSERT : (w < 65) ? ple_pkg::OP_REMOVE :
              (w < 82) ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
      default: op = (w < 35) ? ple_pkg::OP_INSERT : (w < 55) ? ple_pkg::OP_REMOVE :
                    (w < 78) ? ple_pkg::OP_READ : ple_pkg::OP_FIND;
    endcase
    hi = (op == ple_pkg::OP_INSERT) ? gen_len + 1 : gen_len;
    case ($urandom_range(0, 19))
      0: pos = 0;
      1: pos = (hi + 1 > 65) ? 65 : hi + 1;
      2: pos = $urandom_range(0, 65);
      3: pos = hi;
      default: pos = (hi >= 1) ? $urandom_range(1, hi) : 1;
    endcase
    push_op(op, pos, pick_value());
  endtask

  function automatic int pick_delay(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (!(accepted == queued && expected_replies.size() == 0));
  endtask

  task automatic check_reply(list_reply_t exp, list_reply_t act);
    if (act.ok !== exp.ok) begin
      $display("%0t: ok expected %0b actual %0b", $realtime, exp.ok, act.ok);
      errors++;
    end
    if (act.rv !== exp.rv) begin
      $display("%0t: result_value expected %0d actual %0d", $realtime, exp.rv, act.rv);
      errors++;
    end
    if (act.fpos !== exp.fpos) begin
      $display("%0t: found_position expected %0d actual %0d", $realtime, exp.fpos,
               act.fpos);
      errors++;
    end
    if (act.len !== exp.len) begin
      $display("%0t: length expected %0d actual %0d", $realtime, exp.len, act.len);
      errors++;
    end
    if (act.empty !== exp.empty) begin
      $display("%0t: is_empty expected %0b actual %0b", $realtime, exp.empty, act.empty);
      errors++;
    end
  endtask

  always @(negedge clk) begin : drive
    list_op_t o;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          o = pending_ops.pop_front();
          opcode <= o.op;
          position <= o.pos;
          value <= o.val;
          in_valid <= 1'b1;
          gap_left = quiet ? 0 : pick_delay(1'b1);
          // Now and then switch into or out of a stretch with no idling.
          if ($urandom_range(0, 199) == 0) quiet = !quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = pick_delay(1'b0) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    list_op_t o;
    list_reply_t act;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      o.op = opcode;
      o.pos = position;
      o.val = value;
      expected_replies.push_back(apply_list_op(o));
      accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      act.ok = ok;
      act.rv = result_value;
      act.fpos = found_position;
      act.len = length;
      act.empty = is_empty;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0b value=%0d length=%0d",
                 $realtime, ok, result_value, length);
        errors++;
      end else begin
        check_reply(expected_replies.pop_front(), act);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int seg;
    int k;
    // Operations on an empty list all fail.
    push_op(ple_pkg::OP_REMOVE, 1, 32'd5);
    push_op(ple_pkg::OP_READ, 1, 32'd0);
    push_op(ple_pkg::OP_FIND, 0, 32'd0);
    // Bad insert positions.
    push_op(ple_pkg::OP_INSERT, 0, 32'd7);
    push_op(ple_pkg::OP_INSERT, 2, 32'd7);
    push_op(ple_pkg::OP_INSERT, 1, 32'h8000_0000);
    push_op(ple_pkg::OP_INSERT, 2, 32'h7fff_ffff);
    push_op(ple_pkg::OP_INSERT, 1, 32'hffff_ffff);
    push_op(ple_pkg::OP_INSERT, 2, 32'h0000_0000);
    push_op(ple_pkg::OP_READ, 4, 32'd0);
    push_op(ple_pkg::OP_READ, 0, 32'd0);
    push_op(ple_pkg::OP_READ, 5, 32'd0);
    push_op(ple_pkg::OP_FIND, 0, 32'h8000_0000);
    push_op(ple_pkg::OP_FIND, 0, 32'd12345);
    push_op(ple_pkg::OP_INSERT, 65, 32'd1);
    push_op(ple_pkg::OP_INSERT, 5, 32'h5555_aaaa);
    // A duplicate at the head: find must return the first match.
    push_op(ple_pkg::OP_INSERT, 1, 32'h0000_0000);
    push_op(ple_pkg::OP_FIND, 64, 32'h0000_0000);
    push_op(ple_pkg::OP_REMOVE, 7, 32'd0);
    push_op(ple_pkg::OP_REMOVE, 0, 32'd0);
    push_op(ple_pkg::OP_REMOVE, 6, 32'd0);
    push_op(ple_pkg::OP_REMOVE, 1, 32'd0);
    push_op(ple_pkg::OP_READ, 65, 32'hffff_ffff);

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait_drained();
    @(posedge clk);
    for (seg = 0; seg * SEGMENT < NUM_RANDOM; seg++) begin
      for (k = 0; k < SEGMENT; k++) push_random_op(seg % 3);
      // Halfway through, let the whole pipeline empty before going on.
      if (seg == 7) begin
        wait_drained();
        @(posedge clk);
      end
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $realtime,
               expected_replies.size());
      errors += expected_replies.size();
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
